// ===== hdl/sidta_pkg.sv =====
// shared constants for the signed integer to decimal ascii unit
package sidta_pkg;

   // width of the signed input value
   localparam int VALUE_BITS = 32;
   // decimal digits needed for any magnitude up to 2**VALUE_BITS - 1
   localparam int NUM_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
   localparam int BCD_BITS = 4 * NUM_DIGITS;
   localparam int DIG_BITS = $clog2(NUM_DIGITS);
   localparam int CNT_BITS = $clog2(VALUE_BITS);

   // stream word widths
   localparam int CHAR_BITS = 6;
   localparam int REQ_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((CHAR_BITS + 7) / 8) * 8;

   // character codes
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE = 6'd57;

endpackage

// ===== hdl/sidta_bcd_step.sv =====
// one double-dabble step: add-3 adjust of every bcd digit, then shift in one bit
module sidta_bcd_step (
   input  logic [sidta_pkg::BCD_BITS-1:0] bcd_cur,
   input  logic                           bit_in,
   output logic [sidta_pkg::BCD_BITS-1:0] bcd_next
);
   import sidta_pkg::*;

   logic [BCD_BITS-1:0] adjusted;

   // digits of five or more get three added so the shift carries correctly
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_cur[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_cur[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_cur[4*i +: 4];
         end
      end
   end

   // shift left by one, next binary bit enters at the bottom
   assign bcd_next = {adjusted[BCD_BITS-2:0], bit_in};

endmodule

// ===== hdl/signed_int_to_decimal_ascii_unit.sv =====
// top level: signed integer to decimal ascii character stream
// Each req word carries one signed 32-bit value; the unit answers with its
// decimal text on the rsp channel, one ASCII character per word, most
// significant digit first, a leading '-' for negative values, no leading
// zeros, and tlast on the final character (zero gives a single '0').
// After a word is taken the magnitude runs through one shared BCD
// adjust-and-shift unit, one input bit per cycle, then the characters
// leave at one per cycle while rsp_tready stays high. A number is 1 to
// 11 characters long. req_tready is high only while the unit is idle,
// so it is low from the conversion until the last character is loaded.
// The last character sits in an output register, so a new value is
// taken while it still waits for rsp_tready.
module signed_int_to_decimal_ascii_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata fields from bit 0: value (32, signed)
   input  logic [sidta_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata fields from bit 0: ascii_char (6), zero fill (2)
   output logic [sidta_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);
   import sidta_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_step;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIG_BITS-1:0]   idx_ff, idx_in;
   logic [DIG_BITS-1:0]   top_idx;
   logic [CHAR_BITS-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value;
   logic [3:0]            digit;
   logic                  slot_free;
   logic                  req_take;

   // shared conversion unit
   sidta_bcd_step u_bcd_step (
      .bcd_cur  (bcd_ff),
      .bit_in   (mag_ff[VALUE_BITS-1]),
      .bcd_next (bcd_step)
   );

   assign value     = req_tdata[VALUE_BITS-1:0];
   assign req_take  = req_tvalid && req_tready;
   assign slot_free = !valid_ff || rsp_tready;
   assign digit     = bcd_ff[4*idx_ff +: 4];

   // position of the most significant nonzero digit of the finished conversion
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_step[4*i +: 4] != 4'd0) begin
            top_idx = DIG_BITS'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in   = value[VALUE_BITS-1];
               mag_in   = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = bcd_step;
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(VALUE_BITS - 1)) begin
               idx_in   = top_idx;
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               valid_in = 1'b1;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               char_in  = CHAR_ZERO + {2'b00, digit};
               last_in  = (idx_ff == '0);
               valid_in = 1'b1;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - CHAR_BITS){1'b0}}, char_ff};

endmodule

// ===== hdl/sidta_checker.sv =====
// port-level checks for the signed integer to decimal ascii unit
module sidta_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic [sidta_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [sidta_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                                 rsp_tlast,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);
   import sidta_pkg::*;

   logic [CHAR_BITS-1:0] rsp_char;
   assign rsp_char = rsp_tdata[CHAR_BITS-1:0];

   // an offered value word holds until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("req word changed while waiting");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // a taken value is followed by a busy unit, with req_tready low
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again right after a value");

   // only a minus sign or a decimal digit goes out
   a_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_char == CHAR_MINUS || (rsp_char >= CHAR_ZERO && rsp_char <= CHAR_NINE))
      else $error("rsp character out of range");

   // the sign never ends a number
   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_char == CHAR_MINUS |-> !rsp_tlast)
      else $error("minus sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii_unit sidta_checker u_sidta_checker (.*);
